// ----- design/raised_cosine_crossfader_macros.svh -----
// Assertion macros shared by the crossfader RTL.
// Needs a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef RAISED_COSINE_CROSSFADER_MACROS_SVH
`define RAISED_COSINE_CROSSFADER_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define RCX_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define RCX_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- design/rcx_pkg.sv -----
// Package for the raised-cosine crossfader: constants, back-end state type,
// queue status struct and the sine-squared table generator. No dependencies.
package rcx_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int COS_DEPTH_DEF    = 1024;
    localparam int LEN_W            = 24;
    localparam int FACTOR_W         = 17;
    localparam int FRAC_W           = 16;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [FACTOR_W-1:0] FACTOR_ONE   = 17'h10000;
    localparam logic [LEN_W-1:0]    COUNTER_MAX  = 24'hFFFFFF;
    localparam logic [LEN_W-1:0]    LENGTH_RESET = 24'd2048;
    localparam logic [63:0]         Q30_ONE      = 64'd1073741824;
    localparam logic [63:0]         Q30_HALF_PI  = 64'd1686629713;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_LOOK,
        BK_MUL,
        BK_SUM,
        BK_OUT
    } t_bk_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b) >> 30;
    endfunction

    // sin^2(x) for x in unsigned Q30, Horner series to x^11, result Q1.16.
    function automatic logic [FACTOR_W-1:0] rcx_sin_sq(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] sq;
        logic [63:0] r;
        x2 = q30_mul(x, x);
        t  = Q30_ONE - q30_mul(x2, Q30_ONE) / 64'd110;
        t  = Q30_ONE - q30_mul(x2, t) / 64'd72;
        t  = Q30_ONE - q30_mul(x2, t) / 64'd42;
        t  = Q30_ONE - q30_mul(x2, t) / 64'd20;
        t  = Q30_ONE - q30_mul(x2, t) / 64'd6;
        s  = q30_mul(x, t);
        sq = q30_mul(s, s);
        r  = (sq + 64'd8192) >> 14;
        if (r > 64'(FACTOR_ONE)) begin
            r = 64'(FACTOR_ONE);
        end
        return r[FACTOR_W-1:0];
    endfunction

endpackage

// ----- design/rcx_front.sv -----
// Front end of the crossfader: accepts items, applies restart, tags each item
// with its frame position and done flag and pushes it into the queue. Uses rcx_pkg.
module rcx_front import rcx_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    localparam int ITEM_W = 2 * SAMPLE_WIDTH + 2 + LEN_W
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [SAMPLE_WIDTH-1:0] i_old,
    input  logic [SAMPLE_WIDTH-1:0] i_new,
    input  logic                    i_fend,
    input  logic                    i_restart,
    input  logic [LEN_W-1:0]        i_length,
    input  t_q_status               i_q_status,
    output logic                    o_push,
    output logic [ITEM_W-1:0]       o_item
);

    logic [LEN_W-1:0] r_counter;
    logic [LEN_W-1:0] n_counter;
    logic [LEN_W-1:0] w_pos;
    logic             w_done;

    assign w_pos   = i_restart ? '0 : r_counter;
    assign w_done  = (i_length == '0) || (w_pos >= i_length);
    assign o_ready = !i_q_status.full;
    assign o_push  = i_valid && o_ready;
    assign o_item  = {w_pos, w_done, i_fend, i_new, i_old};

    always_comb begin
        n_counter = r_counter;
        if (o_push) begin
            // advance after the last channel of a frame, saturate at the top
            n_counter = (i_fend && (w_pos != COUNTER_MAX)) ? w_pos + 1'b1 : w_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
        end else begin
            r_counter <= n_counter;
        end
    end

endmodule

// ----- design/rcx_queue.sv -----
// Short first-word-fall-through queue between front and back end.
// Uses rcx_pkg for its depth and status struct.
module rcx_queue import rcx_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_status        o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    n_wptr;
    logic [PW-1:0]    r_rptr;
    logic [PW-1:0]    n_rptr;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;

    assign o_data         = r_mem[r_rptr];
    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ----- design/rcx_div.sv -----
// Restoring divider for the table index, one quotient bit per cycle.
// The quotient is known to fit QUO_W bits. Uses rcx_pkg.
module rcx_div import rcx_pkg::*; #(
    parameter int QUO_W = 11,
    localparam int NUM_W = LEN_W + QUO_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_numer,
    input  logic [LEN_W-1:0] i_denom,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quotient
);

    localparam int CW = $clog2(QUO_W + 1);

    logic [LEN_W-1:0] r_rem;
    logic [QUO_W-1:0] r_quo;
    logic [LEN_W-1:0] r_denom;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    n_cnt;
    logic             r_busy;
    logic             n_busy;
    logic             r_done;
    logic             n_done;
    logic [LEN_W:0]   w_trial;
    logic [LEN_W:0]   w_diff;
    logic             w_ge;

    // shift the next numerator bit in from the top of the quotient register
    assign w_trial    = {r_rem, r_quo[QUO_W-1]};
    assign w_ge       = (w_trial >= {1'b0, r_denom});
    assign w_diff     = w_trial - {1'b0, r_denom};
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(QUO_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= i_numer[NUM_W-1:QUO_W];
            r_quo   <= i_numer[QUO_W-1:0];
            r_denom <= i_denom;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[LEN_W-1:0] : w_trial[LEN_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
        end
    end

endmodule

// ----- design/rcx_back.sv -----
// Back end of the crossfader: pops tagged items, finds the mix factor
// (divider plus sine-squared table in the fade, else one), mixes, rounds, saturates and holds the result.
// Uses rcx_pkg and rcx_div.
module rcx_back import rcx_pkg::*; #(
    parameter int SAMPLE_WIDTH       = SAMPLE_WIDTH_DEF,
    parameter int COSINE_TABLE_DEPTH = COS_DEPTH_DEF,
    localparam int ITEM_W = 2 * SAMPLE_WIDTH + 2 + LEN_W
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_q_status               i_q_status,
    input  logic [ITEM_W-1:0]       i_item,
    output logic                    o_pop,
    input  logic [LEN_W-1:0]        i_length,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [SAMPLE_WIDTH-1:0] o_mixed,
    output logic                    o_fend,
    output logic                    o_done,
    output logic [LEN_W-1:0]        o_pos
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int QW     = $clog2(COSINE_TABLE_DEPTH + 1);
    localparam int NUM_W  = LEN_W + QW;
    localparam int PROD_W = SW + 1 + FACTOR_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic signed [SUM_W-1:0] SMAX =
        SUM_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SMIN = -SMAX - 1;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'sd1 <<< (FRAC_W - 1));

    t_bk_state r_state;
    t_bk_state n_state;

    logic [ITEM_W-1:0]          r_item;
    logic [FACTOR_W-1:0]        r_factor;
    logic signed [PROD_W-1:0]   r_prod;
    logic [SW-1:0]              r_mixed;

    logic [FACTOR_W-1:0]        c_table [0:COSINE_TABLE_DEPTH];
    logic [LEN_W-1:0]           w_head_pos;
    logic                       w_head_done;
    logic [NUM_W-1:0]           w_numer;
    logic                       w_div_start;
    logic                       w_div_done;
    logic [QW-1:0]              w_quotient;
    logic signed [SW-1:0]       w_old;
    logic signed [SW-1:0]       w_new;
    logic signed [SW:0]         w_diff;
    logic signed [SUM_W-1:0]    w_sum;
    logic signed [SUM_W-1:0]    w_shift;
    logic signed [SUM_W-1:0]    w_sat;

    // Sine-squared table, built at elaboration; ends pinned to zero and one.
    for (genvar g = 0; g <= COSINE_TABLE_DEPTH; g++) begin : g_tab
        localparam logic [63:0] X = (Q30_HALF_PI * 64'(g)) / 64'(COSINE_TABLE_DEPTH);
        if (g == 0) begin : g_lo
            assign c_table[g] = '0;
        end else if (g == COSINE_TABLE_DEPTH) begin : g_hi
            assign c_table[g] = FACTOR_ONE;
        end else begin : g_mid
            assign c_table[g] = rcx_sin_sq(X);
        end
    end

    assign w_head_pos  = i_item[2*SW+2 +: LEN_W];
    assign w_head_done = i_item[2*SW+1];
    assign w_numer     = NUM_W'(w_head_pos) * NUM_W'(COSINE_TABLE_DEPTH)
                       + NUM_W'(i_length >> 1);

    rcx_div #(
        .QUO_W(QW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_numer    (w_numer),
        .i_denom    (i_length),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // mix as old + (new - old) * f, one multiplier
    assign w_old   = r_item[SW-1:0];
    assign w_new   = r_item[2*SW-1:SW];
    assign w_diff  = {w_new[SW-1], w_new} - {w_old[SW-1], w_old};
    assign w_sum   = (SUM_W'(w_old) <<< FRAC_W) + SUM_W'(r_prod) + ROUND_HALF;
    assign w_shift = w_sum >>> FRAC_W;
    assign w_sat   = (w_shift > SMAX) ? SMAX : ((w_shift < SMIN) ? SMIN : w_shift);

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = w_head_done ? BK_MUL : BK_DIV;
                end
            end
            BK_DIV: begin
                if (w_div_done) begin
                    n_state = BK_LOOK;
                end
            end
            BK_LOOK: n_state = BK_MUL;
            BK_MUL:  n_state = BK_SUM;
            BK_SUM:  n_state = BK_OUT;
            BK_OUT: begin
                if (i_ready) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        w_div_start = 1'b0;
        o_valid     = 1'b0;
        case (r_state)
            BK_IDLE: begin
                o_pop       = !i_q_status.empty;
                w_div_start = !i_q_status.empty && !w_head_done;
            end
            BK_OUT:  o_valid = 1'b1;
            default: o_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item   <= i_item;
            r_factor <= FACTOR_ONE;
        end
        if (r_state == BK_LOOK) begin
            r_factor <= c_table[w_quotient];
        end
        if (r_state == BK_MUL) begin
            r_prod <= w_diff * $signed({1'b0, r_factor});
        end
        if (r_state == BK_SUM) begin
            r_mixed <= w_sat[SW-1:0];
        end
    end

    assign o_mixed = r_mixed;
    assign o_fend  = r_item[2*SW];
    assign o_done  = r_item[2*SW+1];
    assign o_pos   = r_item[2*SW+2 +: LEN_W];

endmodule

// ----- design/raised_cosine_crossfader.sv -----
// Raised-cosine crossfader. One result per input item: the old and new samples of one
// channel are mixed as old*(1-f) + new*f, rounded half up and saturated, with
// f = sin^2(pi/2 * position/length) in Q1.16 from a table of COSINE_TABLE_DEPTH+1 entries.
// The frame position counts frames (tlast) and saturates at 2^24-1; tuser on the input
// clears it before the item is mixed. Once position reaches transition_length, or the
// length is zero, f is exactly one and tuser on the output is set. In the back end,
// an item in the fade passes the states divide, look-up, multiply, sum and output,
// the index divider giving one quotient bit per cycle; an item past the fade skips
// the divider and the look-up. A two-entry queue lets the front accept items while a
// result waits on m_axis_tready. Write the length only while the block is idle.
`include "raised_cosine_crossfader_macros.svh"

module raised_cosine_crossfader import rcx_pkg::*; #(
    parameter int SAMPLE_WIDTH       = SAMPLE_WIDTH_DEF,
    parameter int COSINE_TABLE_DEPTH = COS_DEPTH_DEF,
    localparam int IN_W  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((SAMPLE_WIDTH + LEN_W + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration write channel: transition_length
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [LEN_W-1:0] i_cfg_data,
    // input stream
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // old_sample, new_sample, zero pad
    input  logic             s_axis_tlast,   // frame_end
    input  logic             s_axis_tuser,   // restart
    // output stream
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // mixed_sample, position, zero pad
    output logic             m_axis_tlast,   // frame_end_out
    output logic             m_axis_tuser    // transition_done
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int ITEM_W = 2 * SW + 2 + LEN_W;

    logic [LEN_W-1:0]  r_length;
    logic [LEN_W-1:0]  n_length;
    t_q_status         w_q_status;
    logic              w_push;
    logic              w_pop;
    logic [ITEM_W-1:0] w_push_item;
    logic [ITEM_W-1:0] w_head_item;
    logic [SW-1:0]     w_mixed;
    logic [LEN_W-1:0]  w_pos;

    // Length register; always ready. The user must write it only while idle; the block does not enforce this.
    assign o_cfg_ready = 1'b1;
    assign n_length    = i_cfg_valid ? i_cfg_data : r_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= LENGTH_RESET;
        end else begin
            r_length <= n_length;
        end
    end

    // Front: classify and tag each transaction with position and done flag.
    rcx_front #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_old      (s_axis_tdata[SW-1:0]),
        .i_new      (s_axis_tdata[2*SW-1:SW]),
        .i_fend     (s_axis_tlast),
        .i_restart  (s_axis_tuser),
        .i_length   (r_length),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_item     (w_push_item)
    );

    // Queue: decouple front and back so each stalls on its own.
    rcx_queue #(
        .WIDTH(ITEM_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_push_item),
        .i_pop    (w_pop),
        .o_data   (w_head_item),
        .o_status (w_q_status)
    );

    // Back: factor lookup, mix, round and hold the result for the sink.
    rcx_back #(
        .SAMPLE_WIDTH       (SAMPLE_WIDTH),
        .COSINE_TABLE_DEPTH (COSINE_TABLE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (w_q_status),
        .i_item     (w_head_item),
        .o_pop      (w_pop),
        .i_length   (r_length),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_mixed    (w_mixed),
        .o_fend     (m_axis_tlast),
        .o_done     (m_axis_tuser),
        .o_pos      (w_pos)
    );

    assign m_axis_tdata = OUT_W'({w_pos, w_mixed});

    // A pushed transaction is visible in the queue on the next cycle.
    `RCX_ASSERT_NEXT(a_push_lands, s_axis_tvalid && s_axis_tready, !w_q_status.empty, "push lost")
    // The back end never presents a result right after taking an item.
    `RCX_ASSERT_NEXT(a_pop_no_out, w_pop, !m_axis_tvalid, "result shown too early")
    // Hold the queue head while a result still waits on the sink.
    `RCX_ASSERT_SAME(a_out_blocks, m_axis_tvalid && !m_axis_tready, !w_pop, "pop under stall")

endmodule

// ----- bench/tb_raised_cosine_crossfader.sv -----
// Self-checking bench for raised_cosine_crossfader: drives sample pairs and length writes,
// predicts every mixed sample and compares it with the output stream field by field.
// Depends on rcx_pkg and the crossfader RTL only.
module tb_raised_cosine_crossfader;
    import rcx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW    = SAMPLE_WIDTH_DEF;
    localparam int DEPTH = COS_DEPTH_DEF;
    localparam int IN_W  = ((2 * SW + 7) / 8) * 8;
    localparam int OUT_W = ((SW + LEN_W + 7) / 8) * 8;

    localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic [SW-1:0] S_NEG1 = '1;
    localparam logic [SW-1:0] S_ZERO = '0;

    // one channel sample pair as it enters the block
    typedef struct packed {
        logic [SW-1:0] old_s;
        logic [SW-1:0] new_s;
        logic          frame_end;
        logic          restart;
    } t_pair;

    // one mixed sample as it leaves the block
    typedef struct packed {
        logic [SW-1:0]    mixed;
        logic [LEN_W-1:0] pos;
        logic             frame_end;
        logic             done;
    } t_mix;

    // sin^2(pi/2 * k/DEPTH) in Q1.16: Q30 Horner series to the x^11 term with every
    // product truncated, square rounded half up to Q16 and capped at one
    function automatic logic [FACTOR_W-1:0] sin_sq_entry(input int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] r;
        x  = (Q30_HALF_PI * 64'(k)) / 64'(DEPTH);
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 64'd110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        r  = (((s * s) >> 30) + 64'd8192) >> 14;
        if (r > 64'(FACTOR_ONE)) begin
            r = 64'(FACTOR_ONE);
        end
        return r[FACTOR_W-1:0];
    endfunction

    // Tracks the frame counter, the length register and the fade curve; holds the
    // mixed samples still owed by the block, oldest first.
    class t_mix_ledger;
        logic [FACTOR_W-1:0] ramp [0:DEPTH];
        logic [LEN_W-1:0]    fade_len;
        logic [LEN_W-1:0]    frame_pos;
        logic [FACTOR_W-1:0] last_factor;
        t_mix                pending_mixes[$];
        int                  mismatches;
        int                  checked;
        int                  done_count;
        int                  fade_count;
        int                  restarts;
        int                  top_pos;

        function new();
            for (int k = 0; k <= DEPTH; k++) begin
                ramp[k] = sin_sq_entry(k);
            end
            ramp[0]     = '0;
            ramp[DEPTH] = FACTOR_ONE;
            fade_len    = LENGTH_RESET;
            frame_pos   = '0;
            last_factor = '0;
            mismatches  = 0;
            checked     = 0;
            done_count  = 0;
            fade_count  = 0;
            restarts    = 0;
            top_pos     = 0;
        endfunction

        function void set_length(logic [LEN_W-1:0] len);
            fade_len = len;
        endfunction

        // predict the mix for an accepted pair and advance the frame counter
        function void take_pair(t_pair p);
            t_mix        want;
            logic [63:0] idx;
            longint      w_new;
            longint      acc;
            longint      res;
            if (p.restart) begin
                frame_pos = '0;
                restarts++;
            end
            want.pos       = frame_pos;
            want.frame_end = p.frame_end;
            want.done      = (fade_len == '0) || (frame_pos >= fade_len);
            if (want.done) begin
                last_factor = FACTOR_ONE;
                done_count++;
            end else begin
                idx = (64'(frame_pos) * 64'(DEPTH) + 64'(fade_len / 2)) / 64'(fade_len);
                if (idx > 64'(DEPTH)) begin
                    idx = 64'(DEPTH);
                end
                last_factor = ramp[idx];
                fade_count++;
            end
            w_new = longint'(last_factor);
            acc   = longint'($signed(p.old_s)) * (longint'(FACTOR_ONE) - w_new)
                  + longint'($signed(p.new_s)) * w_new + 64'sd32768;
            res   = acc >>> 16;
            if (res > longint'($signed(S_MAX))) begin
                res = longint'($signed(S_MAX));
            end
            if (res < longint'($signed(S_MIN))) begin
                res = longint'($signed(S_MIN));
            end
            want.mixed = res[SW-1:0];
            pending_mixes.push_back(want);
            if (int'(frame_pos) > top_pos) begin
                top_pos = int'(frame_pos);
            end
            if (p.frame_end && frame_pos < COUNTER_MAX) begin
                frame_pos++;
            end
        endfunction

        task flag_mismatch(string msg);
            mismatches++;
            $display("MISMATCH at %0t ns: %s", $time, msg);
        endtask

        // compare one output transaction against the oldest prediction
        task match_mix(t_mix got);
            t_mix want;
            checked++;
            if (pending_mixes.size() == 0) begin
                flag_mismatch($sformatf("mix %h pos %0d with nothing outstanding",
                                        got.mixed, got.pos));
                return;
            end
            want = pending_mixes.pop_front();
            if (got.mixed !== want.mixed) begin
                flag_mismatch($sformatf("mixed_sample %h, want %h (pos %0d)",
                                        got.mixed, want.mixed, want.pos));
            end
            if (got.pos !== want.pos) begin
                flag_mismatch($sformatf("position %0d, want %0d", got.pos, want.pos));
            end
            if (got.frame_end !== want.frame_end) begin
                flag_mismatch($sformatf("frame_end_out %b, want %b (pos %0d)",
                                        got.frame_end, want.frame_end, want.pos));
            end
            if (got.done !== want.done) begin
                flag_mismatch($sformatf("transition_done %b, want %b (pos %0d)",
                                        got.done, want.done, want.pos));
            end
        endtask
    endclass

    // DUT ports; every input known from time zero
    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_valid   = 1'b0;
    logic             o_cfg_ready;
    logic [LEN_W-1:0] i_cfg_data    = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    logic             s_axis_tlast  = 1'b0;
    logic             s_axis_tuser  = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             m_axis_tlast;
    logic             m_axis_tuser;

    t_mix_ledger ledger = new();

    // idle odds in percent, changed between phases
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int length_writes = 0;
    int pairs_sent    = 0;

    raised_cosine_crossfader dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // old_sample, new_sample, zero pad
        .s_axis_tlast  (s_axis_tlast),   // frame_end
        .s_axis_tuser  (s_axis_tuser),   // restart
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // mixed_sample, position, zero pad
        .m_axis_tlast  (m_axis_tlast),   // frame_end_out
        .m_axis_tuser  (m_axis_tuser)    // transition_done
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver: stall at random with the current odds. Backpressure is drawn fresh
    // every cycle, so runs of ready and of stall are as long as the odds make them.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Output monitor: sample at the edge, before this edge's updates land.
    always @(posedge i_clk) begin : watch_output
        t_mix got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.mixed     = m_axis_tdata[SW-1:0];
            got.pos       = m_axis_tdata[SW +: LEN_W];
            got.frame_end = m_axis_tlast;
            got.done      = m_axis_tuser;
            ledger.match_mix(got);
        end
    end

    function automatic t_pair make_pair(logic [SW-1:0] o, logic [SW-1:0] n,
                                        logic fe, logic rs);
        t_pair p;
        p.old_s     = o;
        p.new_s     = n;
        p.frame_end = fe;
        p.restart   = rs;
        return p;
    endfunction

    // Mostly full-range random samples, with the extremes mixed in often.
    function automatic logic [SW-1:0] pick_sample();
        case ($urandom_range(9))
            0: return S_MAX;
            1: return S_MIN;
            2: return S_ZERO;
            3: return S_NEG1;
            default: return SW'($urandom);
        endcase
    endfunction

    // Present one pair, idling first at the current odds; return at the edge of
    // its transaction with tvalid still high.
    task automatic send_pair(t_pair p);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({p.new_s, p.old_s});
        s_axis_tlast  <= p.frame_end;
        s_axis_tuser  <= p.restart;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        ledger.take_pair(p);
        pairs_sent++;
    endtask

    // Drop the input stream and hold until every owed mix has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (ledger.pending_mixes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    // Length write; only called with the block drained.
    task automatic write_length(logic [LEN_W-1:0] len);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        ledger.set_length(len);
        length_writes++;
    endtask

    // Random traffic: well-formed frames of one to four channels with a rare restart
    // at the frame head, plus a share of pairs with random end and restart marks.
    task automatic random_traffic(int count);
        int sent;
        int chans;
        logic rs;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(7) == 0) begin
                send_pair(make_pair(pick_sample(), pick_sample(),
                                    1'($urandom), ($urandom_range(5) == 0)));
                sent++;
            end else begin
                chans = $urandom_range(1, 4);
                rs    = ($urandom_range(24) == 0);
                for (int c = 0; c < chans && sent < count; c++) begin
                    send_pair(make_pair(pick_sample(), pick_sample(),
                                        (c == chans - 1), rs && (c == 0)));
                    sent++;
                end
            end
        end
    endtask

    logic [LEN_W-1:0] phase_len [8] = '{24'd16, 24'd3, 24'd37, 24'd0,
                                        24'd1, 24'd100, 24'hFFFFFF, LENGTH_RESET};

    initial begin
        // hold reset at the start, once
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset length, sample extremes in both directions
        send_pair(make_pair(S_MAX, S_MIN, 1'b0, 1'b0));
        send_pair(make_pair(S_MIN, S_MAX, 1'b1, 1'b0));
        drain();

        // short fade: walk through it, past the end, then both restart forms
        write_length(24'd4);
        send_pair(make_pair(S_ZERO, S_NEG1, 1'b1, 1'b0));
        send_pair(make_pair(S_MAX, S_MAX, 1'b1, 1'b0));
        send_pair(make_pair(S_MIN, S_MIN, 1'b1, 1'b0));
        send_pair(make_pair(24'd1, 24'hFFFFFE, 1'b1, 1'b0));
        send_pair(make_pair(S_NEG1, S_MAX, 1'b0, 1'b1));
        send_pair(make_pair(S_MAX, S_ZERO, 1'b1, 1'b1));   // restart on a frame end
        send_pair(make_pair(S_ZERO, S_MIN, 1'b1, 1'b0));
        drain();

        // zero length switches at once
        write_length(24'd0);
        send_pair(make_pair(S_MAX, S_MIN, 1'b0, 1'b0));
        send_pair(make_pair(24'h01E240, 24'hF6040F, 1'b1, 1'b0));
        drain();

        // longest fade barely moves the factor
        write_length(24'hFFFFFF);
        send_pair(make_pair(S_MIN, S_MAX, 1'b1, 1'b0));
        send_pair(make_pair(S_MAX, S_MIN, 1'b0, 1'b1));
        drain();

        // one-frame fade: factor zero at position zero, one after
        write_length(24'd1);
        send_pair(make_pair(S_MIN, S_MAX, 1'b1, 1'b1));
        send_pair(make_pair(S_MIN, S_MAX, 1'b1, 1'b0));
        send_pair(make_pair(24'hAAAAAA, 24'h555555, 1'b1, 1'b0));
        drain();

        // Random phases: rotate through the idle patterns, one length each
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 79; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 79; end
                default: begin src_idle_pct = 23; snk_stall_pct = 23; end
            endcase
            write_length(phase_len[ph]);
            random_traffic(56);
            drain();
        end

        // let any stray output show up before the verdict
        snk_stall_pct = 0;
        repeat (40) @(posedge i_clk);

        $display("Run: %0d pairs, %0d mixes checked (%0d in fade, %0d past it), %0d restarts,",
                 pairs_sent, ledger.checked, ledger.fade_count, ledger.done_count,
                 ledger.restarts);
        $display("     %0d length writes incl. 0, 1 and full scale, frame position up to %0d.",
                 length_writes, ledger.top_pos);
        if (ledger.mismatches == 0) begin
            $display("tb_raised_cosine_crossfader passed");
        end else begin
            $display("tb_raised_cosine_crossfader failed");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("TIMEOUT with %0d mixes outstanding", ledger.pending_mixes.size());
        $display("tb_raised_cosine_crossfader failed");
        $finish;
    end

endmodule
